// ===== hw/rtl/nsf_pkg.sv =====
package nsf_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam int NAME_LANES = 6;
  localparam int LANE_IDX_W = 3;
  localparam logic [3:0] NAME_COUNT_MAX = 4'd15;
  localparam logic [7:0] FIELD_COUNT_MAX = 8'hFF;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_NAME   = 2'd1,
    PH_FIELDS = 2'd2,
    PH_CSUM   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_lf;
    logic       is_cr;
    logic       is_ws;
    logic       is_dollar;
    logic       is_star;
    logic       is_comma;
    logic       is_alnum;
    logic       is_field;
    logic       is_hex;
    logic [3:0] hex_val;
  } item_t;

  typedef struct packed {
    logic        sentence_valid;
    logic        checksum_present;
    logic        checksum_ok;
    logic [7:0]  computed_checksum;
    logic [7:0]  received_checksum;
    logic [7:0]  field_count;
    logic [47:0] name_chars;
    logic [3:0]  name_length;
    logic        name_truncated;
  } verdict_t;

endpackage

// ===== hw/rtl/nsf_front.sv =====
module nsf_front import nsf_pkg::*; (
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       q_full,
  output logic       push,
  output item_t      push_item
);

  logic dig, upp, low, hex_uf, hex_lf;

  always_comb begin
    dig    = (in_rx_byte >= 8'h30) && (in_rx_byte <= 8'h39);
    upp    = (in_rx_byte >= 8'h41) && (in_rx_byte <= 8'h5A);
    low    = (in_rx_byte >= 8'h61) && (in_rx_byte <= 8'h7A);
    hex_uf = (in_rx_byte >= 8'h41) && (in_rx_byte <= 8'h46);
    hex_lf = (in_rx_byte >= 8'h61) && (in_rx_byte <= 8'h66);

    push_item.ch        = in_rx_byte;
    push_item.is_lf     = (in_rx_byte == CH_LF);
    push_item.is_cr     = (in_rx_byte == CH_CR);
    push_item.is_ws     = (in_rx_byte == CH_SPACE) || (in_rx_byte == CH_TAB);
    push_item.is_dollar = (in_rx_byte == CH_DOLLAR);
    push_item.is_star   = (in_rx_byte == CH_STAR);
    push_item.is_comma  = (in_rx_byte == CH_COMMA);
    push_item.is_alnum  = dig || upp || low;
    push_item.is_field  = dig || upp || low || (in_rx_byte == CH_DASH) ||
                          (in_rx_byte == CH_DOT);
    push_item.is_hex    = dig || hex_uf || hex_lf;
    if (dig) begin
      push_item.hex_val = in_rx_byte[3:0];
    end else begin
      push_item.hex_val = in_rx_byte[3:0] + 4'd9;
    end
  end

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

endmodule

// ===== hw/rtl/nsf_queue.sv =====
module nsf_queue import nsf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t pop_item,
  output logic  empty,
  output logic  full
);

  item_t              mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;

  assign empty    = (count_r == '0);
  assign full     = (count_r == QCNT_W'(QDEPTH));
  assign pop_item = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hw/rtl/nsf_back.sv =====
module nsf_back import nsf_pkg::*; #(
  parameter int NAME_CHARS = 6
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_empty,
  input  item_t    q_item,
  output logic     pop,
  output logic     res_valid,
  input  logic     res_ready,
  output verdict_t res
);

  localparam int KEEP = (NAME_CHARS < NAME_LANES) ? NAME_CHARS : NAME_LANES;

  phase_t     ph_r, ph_nxt;
  logic [7:0] xr_r, xr_nxt;
  logic [7:0] nb_r [NAME_LANES];
  logic [7:0] nb_nxt [NAME_LANES];
  logic [3:0] nc_r, nc_nxt;
  logic [7:0] fs_r, fs_nxt;
  logic       wf_r, wf_nxt;
  logic [7:0] hv_r, hv_nxt;
  logic [1:0] hd_r, hd_nxt;
  logic       crp_r, crp_nxt;

  logic       out_valid_r, out_valid_nxt;
  verdict_t   out_r;
  verdict_t   verdict;
  logic       lf_pop;
  logic [47:0] packed_name;

  assign pop       = !q_empty && (!q_item.is_lf || !out_valid_r || res_ready);
  assign lf_pop    = pop && q_item.is_lf;
  assign res_valid = out_valid_r;
  assign res       = out_r;

  always_comb begin
    for (int i = 0; i < NAME_LANES; i++) begin
      packed_name[47-8*i -: 8] = nb_r[i];
    end
    verdict.sentence_valid    = wf_r && (nc_r != 4'd0);
    verdict.checksum_present  = (hd_r != 2'd0);
    verdict.checksum_ok       = ((hd_r == 2'd1) || (hd_r == 2'd2)) && (hv_r == xr_r);
    verdict.computed_checksum = xr_r;
    verdict.received_checksum = hv_r;
    verdict.field_count       = fs_r;
    verdict.name_chars        = packed_name;
    verdict.name_length       = nc_r;
    verdict.name_truncated    = (nc_r > 4'(NAME_CHARS));
  end

  always_comb begin
    ph_nxt  = ph_r;
    xr_nxt  = xr_r;
    nb_nxt  = nb_r;
    nc_nxt  = nc_r;
    fs_nxt  = fs_r;
    wf_nxt  = wf_r;
    hv_nxt  = hv_r;
    hd_nxt  = hd_r;
    crp_nxt = crp_r;
    if (pop) begin
      if (q_item.is_lf) begin
        crp_nxt = 1'b0;
        ph_nxt  = PH_HUNT;
        xr_nxt  = '0;
        for (int i = 0; i < NAME_LANES; i++) begin
          nb_nxt[i] = '0;
        end
        nc_nxt  = '0;
        fs_nxt  = '0;
        wf_nxt  = 1'b0;
        hv_nxt  = '0;
        hd_nxt  = '0;
      end else begin
        // held cr taken as an ordinary byte first
        if (crp_r) begin
          crp_nxt = 1'b0;
          case (ph_r)
            PH_NAME, PH_FIELDS: begin
              xr_nxt = xr_r ^ CH_CR;
              wf_nxt = 1'b0;
            end
            PH_CSUM: begin
              if ((hd_r == 2'd1) || (hd_r == 2'd2)) begin
                hd_nxt = 2'd3;
              end
            end
            default: begin
            end
          endcase
        end
        if (q_item.is_cr) begin
          crp_nxt = 1'b1;
        end else if (!q_item.is_ws) begin
          if (q_item.is_dollar) begin
            ph_nxt = PH_NAME;
            xr_nxt = '0;
            for (int i = 0; i < NAME_LANES; i++) begin
              nb_nxt[i] = '0;
            end
            nc_nxt = '0;
            fs_nxt = '0;
            wf_nxt = 1'b1;
            hv_nxt = '0;
            hd_nxt = '0;
          end else begin
            case (ph_r)
              PH_NAME: begin
                if (q_item.is_star) begin
                  ph_nxt = PH_CSUM;
                end else begin
                  xr_nxt = xr_nxt ^ q_item.ch;
                  if (q_item.is_alnum) begin
                    if (nc_r < 4'(KEEP)) begin
                      nb_nxt[nc_r[LANE_IDX_W-1:0]] = q_item.ch;
                    end
                    if (nc_r != NAME_COUNT_MAX) begin
                      nc_nxt = nc_r + 4'd1;
                    end
                  end else if (q_item.is_comma) begin
                    if (nc_r == 4'd0) begin
                      wf_nxt = 1'b0;
                    end
                    ph_nxt = PH_FIELDS;
                    fs_nxt = 8'd1;
                  end else begin
                    wf_nxt = 1'b0;
                  end
                end
              end
              PH_FIELDS: begin
                if (q_item.is_star) begin
                  ph_nxt = PH_CSUM;
                end else begin
                  xr_nxt = xr_nxt ^ q_item.ch;
                  if (q_item.is_comma) begin
                    if (fs_r != FIELD_COUNT_MAX) begin
                      fs_nxt = fs_r + 8'd1;
                    end
                  end else if (!q_item.is_field) begin
                    wf_nxt = 1'b0;
                  end
                end
              end
              PH_CSUM: begin
                if (q_item.is_hex) begin
                  if (hd_nxt < 2'd2) begin
                    hv_nxt = {hv_r[3:0], q_item.hex_val};
                    hd_nxt = hd_nxt + 2'd1;
                  end else begin
                    hd_nxt = 2'd3;
                  end
                end else begin
                  if (q_item.is_star) begin
                    wf_nxt = 1'b0;
                  end
                  if ((hd_nxt == 2'd1) || (hd_nxt == 2'd2)) begin
                    hd_nxt = 2'd3;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (lf_pop) begin
      out_valid_nxt = 1'b1;
    end else if (res_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= PH_HUNT;
      xr_r        <= '0;
      nc_r        <= '0;
      fs_r        <= '0;
      wf_r        <= 1'b0;
      hv_r        <= '0;
      hd_r        <= '0;
      crp_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NAME_LANES; i++) begin
        nb_r[i] <= '0;
      end
    end else begin
      ph_r        <= ph_nxt;
      xr_r        <= xr_nxt;
      nc_r        <= nc_nxt;
      fs_r        <= fs_nxt;
      wf_r        <= wf_nxt;
      hv_r        <= hv_nxt;
      hd_r        <= hd_nxt;
      crp_r       <= crp_nxt;
      out_valid_r <= out_valid_nxt;
      nb_r        <= nb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (lf_pop) begin
      out_r <= verdict;
    end
  end

endmodule

// ===== hw/rtl/nmea_sentence_framer_top.sv =====
// a verdict is registered onto the out_ ports when the back end pops its line feed from the queue
// throughput: one byte per cycle while the queue is not full; the back end retires one queued item per cycle
// unless a line feed waits in the four-entry queue, which it does only while the previous verdict is not taken
// reset (rst_n low, synchronous) empties the queue, drops any held verdict
// and returns the framer to hunting for a dollar sign with all sentence state zero
module nmea_sentence_framer_top import nsf_pkg::*; #(
  parameter int NAME_CHARS = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_sentence_valid,
  output logic        out_checksum_present,
  output logic        out_checksum_ok,
  output logic [7:0]  out_computed_checksum,
  output logic [7:0]  out_received_checksum,
  output logic [7:0]  out_field_count,
  output logic [47:0] out_name_chars,
  output logic [3:0]  out_name_length,
  output logic        out_name_truncated
);

  logic     push, pop, q_empty, q_full;
  item_t    push_item, pop_item;
  verdict_t res;

  nsf_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .push       (push),
    .push_item  (push_item)
  );

  nsf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (q_empty),
    .full      (q_full)
  );

  nsf_back #(
    .NAME_CHARS (NAME_CHARS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_item    (pop_item),
    .pop       (pop),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  assign out_sentence_valid    = res.sentence_valid;
  assign out_checksum_present  = res.checksum_present;
  assign out_checksum_ok       = res.checksum_ok;
  assign out_computed_checksum = res.computed_checksum;
  assign out_received_checksum = res.received_checksum;
  assign out_field_count       = res.field_count;
  assign out_name_chars        = res.name_chars;
  assign out_name_length       = res.name_length;
  assign out_name_truncated    = res.name_truncated;

endmodule
